@@ rtl/assert_macros.svh @@
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with its own failure message, held off during reset
`define OWB_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion with a generic failure message
`define OWB_ASSERT(lbl, clk, rst_n, prop) \
    `OWB_ASSERT_MSG(lbl, clk, rst_n, prop, "owb assertion failed")

`endif

@@ rtl/owb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_pkg
// Types and constants shared by the single-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // phase durations in microsecond ticks (reset low time is a parameter)
    localparam logic [8:0] RST_WAIT_TIME = 9'd70;
    localparam logic [8:0] RST_REC_TIME  = 9'd410;
    localparam logic [8:0] WR1_LOW_TIME  = 9'd10;
    localparam logic [8:0] WR0_LOW_TIME  = 9'd60;
    localparam logic [8:0] WR1_HIGH_TIME = 9'd55;
    localparam logic [8:0] WR0_HIGH_TIME = 9'd5;
    localparam logic [8:0] RD_LOW_TIME   = 9'd3;
    localparam logic [8:0] RD_WAIT_TIME  = 9'd10;
    localparam logic [8:0] RD_REC_TIME   = 9'd50;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_RST_LOW  = 9'b000000010,
        PH_RST_WAIT = 9'b000000100,
        PH_RST_REC  = 9'b000001000,
        PH_WR_LOW   = 9'b000010000,
        PH_WR_HIGH  = 9'b000100000,
        PH_RD_LOW   = 9'b001000000,
        PH_RD_WAIT  = 9'b010000000,
        PH_RD_REC   = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       line_level;
    } t_owb_req;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } t_owb_res;

endpackage

@@ rtl/owb_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_core
// Bus sequencer: phase, tick counter, bit counter and shift register. Works
// out the next state and the result for the item on its input; the state
// moves on when the item is accepted.
// ----------------------------------------------------------------------------
module owb_core #(
    parameter int RESET_LOW_TIME = 480
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  owb_pkg::t_owb_req i_req,
    output owb_pkg::t_owb_res o_res
);
    import owb_pkg::*;

    localparam logic [8:0] RstLowTime = 9'(RESET_LOW_TIME);

    t_phase     r_phase, n_phase;
    logic [8:0] r_time, n_time;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_presence, n_presence;
    logic [7:0] r_last_read, n_last_read;

    logic [8:0] w_len;
    logic [8:0] w_time_inc;
    logic       w_done;
    logic       w_rej;

    // duration of the current phase
    always_comb begin
        unique case (r_phase)
            PH_RST_LOW:  w_len = RstLowTime;
            PH_RST_WAIT: w_len = RST_WAIT_TIME;
            PH_RST_REC:  w_len = RST_REC_TIME;
            PH_WR_LOW:   w_len = r_shift[0] ? WR1_LOW_TIME : WR0_LOW_TIME;
            PH_WR_HIGH:  w_len = r_shift[0] ? WR1_HIGH_TIME : WR0_HIGH_TIME;
            PH_RD_LOW:   w_len = RD_LOW_TIME;
            PH_RD_WAIT:  w_len = RD_WAIT_TIME;
            PH_RD_REC:   w_len = RD_REC_TIME;
            default:     w_len = 9'd1;
        endcase
    end

    assign w_time_inc = r_time + 9'd1;

    always_comb begin
        n_phase     = r_phase;
        n_time      = r_time;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        w_done      = 1'b0;
        w_rej       = 1'b0;

        if (i_req.req_type == REQ_TICK) begin
            if (r_phase != PH_IDLE) begin
                n_time = w_time_inc;
                if (w_time_inc >= w_len) begin
                    n_time = '0;
                    unique case (r_phase)
                        PH_RST_LOW: n_phase = PH_RST_WAIT;
                        PH_RST_WAIT: begin
                            // device answers by holding the line low
                            n_presence = ~i_req.line_level;
                            n_phase    = PH_RST_REC;
                        end
                        PH_RST_REC: begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end
                        PH_WR_LOW: n_phase = PH_WR_HIGH;
                        PH_WR_HIGH: begin
                            n_shift = {1'b0, r_shift[7:1]};
                            if (r_bit == LAST_BIT) begin
                                n_phase = PH_IDLE;
                                n_bit   = '0;
                                w_done  = 1'b1;
                            end else begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = PH_WR_LOW;
                            end
                        end
                        PH_RD_LOW: n_phase = PH_RD_WAIT;
                        PH_RD_WAIT: begin
                            // lsb first, so each sample enters at the top
                            n_shift = {i_req.line_level, r_shift[7:1]};
                            n_phase = PH_RD_REC;
                        end
                        PH_RD_REC: begin
                            if (r_bit == LAST_BIT) begin
                                n_last_read = r_shift;
                                n_phase     = PH_IDLE;
                                n_bit       = '0;
                                w_done      = 1'b1;
                            end else begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = PH_RD_LOW;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            w_rej = 1'b1;
        end else begin
            n_time = '0;
            n_bit  = '0;
            priority case (i_req.req_type)
                REQ_RESET: n_phase = PH_RST_LOW;
                REQ_WRITE: begin
                    n_shift = i_req.data_byte;
                    n_phase = PH_WR_LOW;
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_RD_LOW;
                end
            endcase
        end
    end

    always_comb begin
        o_res.drive_low = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW)
                          || (n_phase == PH_RD_LOW);
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = w_done;
        o_res.presence  = n_presence;
        o_res.read_data = n_last_read;
        o_res.rejected  = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_time      <= n_time;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_last_read <= n_last_read;
        end
    end

endmodule

@@ rtl/one_wire_bus_master.sv @@
// Single-wire bus master. Each input item is either a one-microsecond tick
// carrying the sampled bus level, or a command starting a reset/presence,
// byte write or byte read sequence; every item gives exactly one result with
// the open-drain drive, busy, done, presence, last read byte and a rejected
// flag for commands that arrive while busy. One item is taken per clock
// unless stalled; its result is held in the output register and appears in
// the cycle after acceptance. That register decouples the two sides, so the
// input is stalled only while a result is waiting and the output is stalled.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Top level: item handshake, sequencer and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module one_wire_bus_master #(
    parameter int RESET_LOW_TIME = 480
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  owb_pkg::t_owb_req i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output owb_pkg::t_owb_res o_out_item
);
    import owb_pkg::*;

    logic     w_accept;
    t_owb_res w_res;
    logic     r_out_valid;
    t_owb_res r_out_item;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    owb_core #(
        .RESET_LOW_TIME (RESET_LOW_TIME)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_in_item),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `OWB_ASSERT(a_drive_needs_busy, i_clk, i_rst_n, r_out_valid |-> (!r_out_item.drive_low || r_out_item.busy_res))
    `OWB_ASSERT(a_done_leaves_idle, i_clk, i_rst_n, r_out_valid |-> (!r_out_item.done_res || !r_out_item.busy_res))
    `OWB_ASSERT_MSG(a_reject_when_busy, i_clk, i_rst_n, r_out_valid |-> (!r_out_item.rejected || r_out_item.busy_res), "rejected item while idle")

endmodule
